// ===== rtl/sha256_byte_stream_hasher_assert.svh =====
// Assertion macros shared by the SHA-256 byte stream hasher modules
`ifndef SHA256_BYTE_STREAM_HASHER_ASSERT_SVH
`define SHA256_BYTE_STREAM_HASHER_ASSERT_SVH

// same-cycle implication, clocked on clk, quiet during rst
`define SBSH_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk, quiet during rst
`define SBSH_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/sbsh_pkg.sv =====
// Types, constants and round functions of the SHA-256 byte stream hasher
`default_nettype none

package sbsh_pkg;

  typedef logic [31:0] word_t;

  // one classified request from the front to the back
  typedef struct packed {
    logic [7:0] data;
    logic       has_byte;
    logic       is_end;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_PAD2,
    ST_ROUND,
    ST_FINAL
  } state_t;

  // what the block being compressed is
  typedef enum logic [1:0] {
    BLK_DATA,
    BLK_MORE,
    BLK_LAST
  } blk_t;

  localparam logic [7:0] PAD_BYTE  = 8'h80;
  localparam logic [5:0] LEN_POS   = 6'd56;
  localparam logic [5:0] LAST_POS  = 6'd63;
  localparam logic [5:0] LAST_RND  = 6'd63;
  localparam logic [1:0] LAST_WORD = 2'd3;

  localparam word_t ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam word_t INIT_H [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  function automatic word_t big0(input word_t a);
    return {a[1:0], a[31:2]} ^ {a[12:0], a[31:13]} ^ {a[21:0], a[31:22]};
  endfunction

  function automatic word_t big1(input word_t e);
    return {e[5:0], e[31:6]} ^ {e[10:0], e[31:11]} ^ {e[24:0], e[31:25]};
  endfunction

  function automatic word_t small0(input word_t x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic word_t small1(input word_t y);
    return {y[16:0], y[31:17]} ^ {y[18:0], y[31:19]} ^ {10'b0, y[31:10]};
  endfunction

endpackage

`default_nettype wire

// ===== rtl/sbsh_front.sv =====
// Front: accepts input items, drops idle ones and queues byte and end requests
`default_nettype none

module sbsh_front import sbsh_pkg::*; #(
  parameter int unsigned QDepth = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] data_byte,
  input  logic       byte_valid,
  input  logic       last,
  output cmd_t       cmd,
  output logic       cmd_valid,
  input  logic       cmd_pop
);

  localparam int unsigned PtrW = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int unsigned CntW = $clog2(QDepth + 1);
  localparam logic [CntW-1:0] CntFull = CntW'(QDepth);

  cmd_t            q [QDepth];
  cmd_t            q_in;
  logic [CntW-1:0] cnt;
  logic [PtrW-1:0] wr_idx;
  logic            take;
  logic            keep;
  logic            q_push;
  logic            q_pop;

  assign full      = (cnt == CntFull);
  assign take      = push && !full;
  assign keep      = byte_valid || last;
  assign q_push    = take && keep;
  assign cmd_valid = (cnt != '0);
  assign q_pop     = cmd_pop && cmd_valid;
  assign cmd       = q[0];
  assign wr_idx    = PtrW'(cnt - CntW'(q_pop));
  assign q_in      = '{data: data_byte, has_byte: byte_valid, is_end: last};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else begin
      cnt <= cnt + CntW'(q_push) - CntW'(q_pop);
    end
  end

  // head sits in entry 0; a pop shifts the rest down
  always_ff @(posedge clk) begin
    for (int i = 0; i < int'(QDepth) - 1; i++) begin
      if (q_push && wr_idx == PtrW'(i)) begin
        q[i] <= q_in;
      end else if (q_pop) begin
        q[i] <= q[i + 1];
      end
    end
    if (q_push && wr_idx == PtrW'(QDepth - 1)) begin
      q[QDepth - 1] <= q_in;
    end
  end

`include "sha256_byte_stream_hasher_assert.svh"

  `SBSH_ASSERT_NOW(a_cnt_bound, 1'b1, cnt <= CntFull, "request queue count beyond depth")
  `SBSH_ASSERT_NEXT(a_idle_dropped, take && !keep && !q_pop, cnt == $past(cnt),
                    "idle request entered the queue")
  `SBSH_ASSERT_NEXT(a_push_counts, q_push && !q_pop, cnt == $past(cnt) + CntW'(1),
                    "queued request not counted")

endmodule

`default_nettype wire

// ===== rtl/sbsh_core.sv =====
// Back: block buffer, padding, one-round-per-cycle compression and digest buffer
`default_nettype none

module sbsh_core import sbsh_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  input  logic        cmd_valid,
  output logic        cmd_pop,
  output logic        empty,
  input  logic        pop,
  output logic [63:0] digest_word,
  output logic [1:0]  word_index,
  output logic        last_word
);

  state_t      state;
  state_t      state_next;
  blk_t        blk;
  logic        end_pend;
  logic [60:0] msg_cnt;
  word_t       hash [8];
  word_t       v [8];
  word_t       w [16];
  word_t       dig [8];
  logic [5:0]  rnd;
  logic        out_busy;
  logic [1:0]  out_idx;

  logic [5:0]  pos;
  logic [63:0] len_bits;
  word_t       t1;
  word_t       t2;
  word_t       w_new;
  word_t       hash_sum [8];
  word_t       pad_word [16];

  assign pos      = msg_cnt[5:0];
  assign len_bits = {msg_cnt, 3'b000};
  assign t1 = v[7] + big1(v[4]) + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[rnd] + w[0];
  assign t2 = big0(v[0]) + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
  assign w_new = small1(w[14]) + w[9] + small0(w[1]) + w[0];

  always_comb begin
    for (int j = 0; j < 8; j++) begin
      hash_sum[j] = hash[j] + v[j];
    end
  end

  // 0x80 at the fill position, zeros after it, earlier bytes kept
  always_comb begin
    for (int j = 0; j < 16; j++) begin
      for (int b = 0; b < 4; b++) begin
        if (6'(4 * j + b) == pos) begin
          pad_word[j][31 - 8 * b -: 8] = PAD_BYTE;
        end else if (6'(4 * j + b) > pos) begin
          pad_word[j][31 - 8 * b -: 8] = 8'h00;
        end else begin
          pad_word[j][31 - 8 * b -: 8] = w[j][31 - 8 * b -: 8];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd_pop    = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (cmd_valid) begin
          cmd_pop = 1'b1;
          if (cmd.has_byte && pos == LAST_POS) begin
            state_next = ST_ROUND;
          end else if (cmd.is_end) begin
            state_next = ST_PAD;
          end
        end
      end
      ST_PAD:   state_next = ST_ROUND;
      ST_PAD2:  state_next = ST_ROUND;
      ST_ROUND: begin
        if (rnd == LAST_RND) begin
          state_next = ST_FINAL;
        end
      end
      ST_FINAL: begin
        unique case (blk)
          BLK_DATA: state_next = end_pend ? ST_PAD : ST_IDLE;
          BLK_MORE: state_next = ST_PAD2;
          BLK_LAST: begin
            if (!out_busy) begin
              state_next = ST_IDLE;
            end
          end
          default:  state_next = ST_IDLE;
        endcase
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hash     <= INIT_H;
      msg_cnt  <= '0;
      end_pend <= 1'b0;
      blk      <= BLK_DATA;
      rnd      <= '0;
      out_busy <= 1'b0;
      out_idx  <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (cmd_valid) begin
            end_pend <= cmd.is_end;
            blk      <= BLK_DATA;
            if (cmd.has_byte) begin
              w[pos[5:2]][{~pos[1:0], 3'b000} +: 8] <= cmd.data;
              msg_cnt <= msg_cnt + 61'd1;
              v       <= hash;
              rnd     <= '0;
            end
          end
        end
        ST_PAD: begin
          for (int j = 0; j < 14; j++) begin
            w[j] <= pad_word[j];
          end
          if (pos >= LEN_POS) begin
            w[14] <= pad_word[14];
            w[15] <= pad_word[15];
            blk   <= BLK_MORE;
          end else begin
            w[14] <= len_bits[63:32];
            w[15] <= len_bits[31:0];
            blk   <= BLK_LAST;
          end
          v   <= hash;
          rnd <= '0;
        end
        ST_PAD2: begin
          for (int j = 0; j < 14; j++) begin
            w[j] <= '0;
          end
          w[14] <= len_bits[63:32];
          w[15] <= len_bits[31:0];
          blk   <= BLK_LAST;
          v     <= hash;
          rnd   <= '0;
        end
        ST_ROUND: begin
          v[0] <= t1 + t2;
          v[1] <= v[0];
          v[2] <= v[1];
          v[3] <= v[2];
          v[4] <= v[3] + t1;
          v[5] <= v[4];
          v[6] <= v[5];
          v[7] <= v[6];
          for (int j = 0; j < 15; j++) begin
            w[j] <= w[j + 1];
          end
          w[15] <= w_new;
          rnd   <= rnd + 6'd1;
        end
        ST_FINAL: begin
          if (blk == BLK_LAST) begin
            if (!out_busy) begin
              dig      <= hash_sum;
              hash     <= INIT_H;
              msg_cnt  <= '0;
              end_pend <= 1'b0;
              out_busy <= 1'b1;
              out_idx  <= '0;
            end
          end else begin
            hash <= hash_sum;
          end
        end
        default: begin
        end
      endcase

      if (pop && out_busy) begin
        for (int j = 0; j < 6; j++) begin
          dig[j] <= dig[j + 2];
        end
        out_idx <= out_idx + 2'd1;
        if (out_idx == LAST_WORD) begin
          out_busy <= 1'b0;
        end
      end
    end
  end

  assign empty       = !out_busy;
  assign digest_word = {dig[0], dig[1]};
  assign word_index  = out_idx;
  assign last_word   = (out_idx == LAST_WORD);

`include "sha256_byte_stream_hasher_assert.svh"

  `SBSH_ASSERT_NEXT(a_digest_load, state == ST_FINAL && blk == BLK_LAST && !out_busy,
                    out_busy && out_idx == 2'd0 && msg_cnt == '0,
                    "digest not loaded or message not restarted")
  `SBSH_ASSERT_NEXT(a_pad_starts, state == ST_PAD || state == ST_PAD2,
                    state == ST_ROUND && rnd == 6'd0, "padding did not start a block")
  `SBSH_ASSERT_NEXT(a_out_drain, out_busy && pop && out_idx == LAST_WORD, !out_busy,
                    "digest buffer not freed after fourth word")

endmodule

`default_nettype wire

// ===== rtl/sha256_byte_stream_hasher.sv =====
// Top level of the SHA-256 byte stream hasher
//
//  channel  | handshake          | payload
//  ---------+--------------------+------------------------------------
//  input    | push / full        | data_byte, byte_valid, last
//  result   | empty / pop        | digest_word, word_index, last_word
//
// Each byte is written into the block buffer; each 64th byte starts the round loop,
// followed by the hash update that adds the working variables into the hash state.
// An end request runs the padding and then compresses one or two final blocks.
// The QDepth-entry request queue keeps taking items during compression;
// the digest sits in its own buffer, so the next message runs while it drains.
// Reset restores the initial hash values and clears both queues.
`default_nettype none

module sha256_byte_stream_hasher import sbsh_pkg::*; #(
  parameter int unsigned QDepth = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  data_byte,
  input  logic        byte_valid,
  input  logic        last,
  output logic        empty,
  input  logic        pop,
  output logic [63:0] digest_word,
  output logic [1:0]  word_index,
  output logic        last_word
);

  cmd_t cmd;
  logic cmd_valid;
  logic cmd_pop;

  sbsh_front #(
    .QDepth(QDepth)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .data_byte (data_byte),
    .byte_valid(byte_valid),
    .last      (last),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop)
  );

  sbsh_core u_core (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .cmd_valid  (cmd_valid),
    .cmd_pop    (cmd_pop),
    .empty      (empty),
    .pop        (pop),
    .digest_word(digest_word),
    .word_index (word_index),
    .last_word  (last_word)
  );

endmodule

`default_nettype wire
